// ===== rtl/kcf_pkg.sv =====
`default_nettype none
package kcf_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int KEY_COUNT   = 128;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W       = $clog2(KEY_COUNT);
    localparam int SLOT_W      = 4;

    localparam logic [SLOT_W-1:0] NOT_HELD = 4'd8;

    localparam logic [63:0] USED_BITS  = 64'h8080_8080_8080_8080;
    localparam logic [18:0] CTRL_RESET = 19'h10000;
    localparam logic [19:0] TIMEOUT_RESET = 20'h27100;
    localparam logic [19:0] DELAY_RESET   = 20'h00400;

    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [5:0] A_CTRL    = 6'd0;
    localparam logic [5:0] A_INT     = 6'd1;
    localparam logic [5:0] A_ROW0    = 6'd2;
    localparam logic [5:0] A_ROW3    = 6'd5;
    localparam logic [5:0] A_COL0    = 6'd6;
    localparam logic [5:0] A_COL2    = 6'd8;
    localparam logic [5:0] A_TIMEOUT = 6'd9;
    localparam logic [5:0] A_INIT    = 6'd10;
    localparam logic [5:0] A_REPEAT  = 6'd11;
    localparam logic [5:0] A_POP     = 6'd12;
    localparam logic [5:0] A_HIGH    = 6'd13;
    localparam logic [5:0] A_MASK0   = 6'd14;
    localparam logic [5:0] A_MASK15  = 6'd29;

    localparam int CTRL_EN       = 0;
    localparam int CTRL_PRESS_IE = 1;
    localparam int CTRL_OVF_IE   = 2;
    localparam int CTRL_CNT_IE   = 3;

    localparam int FLAG_KEY = 0;
    localparam int FLAG_OVF = 1;
    localparam int FLAG_CNT = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  word_address;
        logic [31:0] write_data;
        logic [6:0]  scan_code;
        logic        key_release;
        logic [7:0]  key_code;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
    } t_out_item;

    typedef struct packed {
        logic              rd_en;
        logic [KEY_W-1:0]  rd_addr;
        logic              wr_en;
        logic [KEY_W-1:0]  wr_addr;
        logic [SLOT_W-1:0] wr_data;
    } t_slot_req;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/kcf_ram.sv =====
`default_nettype none
module kcf_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== rtl/kcf_slot_mem.sv =====
`default_nettype none
module kcf_slot_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire kcf_pkg::t_slot_req         i_req,
    output logic [kcf_pkg::SLOT_W-1:0]      o_rd_data
);

    logic [kcf_pkg::SLOT_W-1:0]    r_mem [kcf_pkg::KEY_COUNT];
    logic [kcf_pkg::KEY_COUNT-1:0] r_valid;
    logic [kcf_pkg::SLOT_W-1:0]    r_rd_data;
    logic                          r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    // unwritten entries read as not held
    assign o_rd_data = r_rd_valid ? r_rd_data : kcf_pkg::NOT_HELD;

endmodule
`default_nettype wire

// ===== rtl/keypad_controller_with_fifo.sv =====
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_stall      i_in_item  (kcf_pkg::t_in_item)
// out       output     o_out_valid / i_out_stall    o_out_item (kcf_pkg::t_out_item)
//
// Every item reads the key slot map and the entry queue memories when it is
// accepted, then is modified and written back in the execute state.
// The next item is taken once the previous result has entered the output register.
// Reset is synchronous; the slot map is cleared at once through per-key valid bits.
// A stalled result holds the block in its execute cycle.
`default_nettype none
module keypad_controller_with_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire kcf_pkg::t_in_item  i_in_item,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output kcf_pkg::t_out_item      o_out_item,
    input  wire logic               i_out_stall
);

    localparam int QA_W  = kcf_pkg::QA_W;
    localparam int QC_W  = kcf_pkg::QC_W;
    localparam int KEY_W = kcf_pkg::KEY_W;

    kcf_pkg::t_state    r_state, n_state;
    kcf_pkg::t_in_item  r_item, n_item;
    kcf_pkg::t_out_item r_out_item, n_out_item;
    logic               r_out_valid, n_out_valid;

    logic [18:0] r_ctrl, n_ctrl;
    logic [2:0]  r_flags, n_flags;
    logic [29:0] r_row [4];
    logic [29:0] n_row [4];
    logic [31:0] r_col [3];
    logic [31:0] n_col [3];
    logic [19:0] r_timeout, n_timeout;
    logic [19:0] r_init, n_init;
    logic [19:0] r_rep, n_rep;
    logic [7:0]  r_mask [16];
    logic [7:0]  n_mask [16];
    logic [63:0] r_held, n_held;
    logic [QA_W-1:0] r_head, n_head;
    logic [QC_W-1:0] r_count, n_count;
    logic [63:0] r_latched, n_latched;

    kcf_pkg::t_slot_req          slot_req;
    logic [kcf_pkg::SLOT_W-1:0]  slot_rd;
    logic                        q_wr_en;
    logic [QA_W-1:0]             q_wr_addr;
    logic [63:0]                 q_rd;
    logic                        accept;

    kcf_slot_mem u_slot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (slot_req),
        .o_rd_data (slot_rd)
    );

    kcf_ram #(
        .DEPTH (kcf_pkg::QUEUE_DEPTH),
        .WIDTH (64)
    ) u_queue_mem (
        .i_clk     (i_clk),
        .i_wr_en   (q_wr_en),
        .i_wr_addr (q_wr_addr),
        .i_wr_data (n_held),
        .i_rd_en   (accept),
        .i_rd_addr (r_head),
        .o_rd_data (q_rd)
    );

    assign accept      = i_in_valid && (r_state == kcf_pkg::S_IDLE);
    assign o_in_stall  = (r_state != kcf_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        logic            out_free;
        logic [63:0]     freebits;
        logic            found;
        logic [2:0]      open_slot;
        logic [QC_W:0]   tail_sum;
        logic [5:0]      a_row;
        logic [5:0]      a_col;
        logic [5:0]      a_mask;
        logic [31:0]     rd;
        logic            do_raise;
        logic            is_event;

        out_free  = !r_out_valid || !i_out_stall;
        freebits  = ~r_held & kcf_pkg::USED_BITS;
        found     = 1'b0;
        open_slot = '0;
        tail_sum  = (QC_W+1)'(r_head) + (QC_W+1)'(r_count);
        a_row     = r_item.word_address - kcf_pkg::A_ROW0;
        a_col     = r_item.word_address - kcf_pkg::A_COL0;
        a_mask    = r_item.word_address - kcf_pkg::A_MASK0;
        rd        = '0;
        do_raise  = 1'b0;
        is_event  = 1'b0;

        n_state     = r_state;
        n_item      = r_item;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        n_ctrl      = r_ctrl;
        n_flags     = r_flags;
        n_row       = r_row;
        n_col       = r_col;
        n_timeout   = r_timeout;
        n_init      = r_init;
        n_rep       = r_rep;
        n_mask      = r_mask;
        n_held      = r_held;
        n_head      = r_head;
        n_count     = r_count;
        n_latched   = r_latched;

        slot_req.rd_en   = accept;
        slot_req.rd_addr = i_in_item.scan_code[KEY_W-1:0];
        slot_req.wr_en   = 1'b0;
        slot_req.wr_addr = r_item.scan_code[KEY_W-1:0];
        slot_req.wr_data = kcf_pkg::NOT_HELD;
        q_wr_en          = 1'b0;
        q_wr_addr        = (tail_sum >= (QC_W+1)'(kcf_pkg::QUEUE_DEPTH))
                         ? QA_W'(tail_sum - (QC_W+1)'(kcf_pkg::QUEUE_DEPTH))
                         : QA_W'(tail_sum);

        for (int s = 7; s >= 0; s--) begin
            if (freebits[s*8+7]) begin
                found     = 1'b1;
                open_slot = 3'(s);
            end
        end

        if (accept) begin
            n_state = kcf_pkg::S_EXEC;
            n_item  = i_in_item;
        end

        if (r_state == kcf_pkg::S_EXEC && out_free) begin
            n_state = kcf_pkg::S_IDLE;
            case (r_item.kind)
                kcf_pkg::KIND_EVENT: begin
                    if (r_ctrl[kcf_pkg::CTRL_EN]) begin
                        is_event = 1'b1;
                        do_raise = 1'b1;
                        if (r_item.key_release) begin
                            if (!slot_rd[3]) begin
                                n_held = r_held & ~(64'hff << {slot_rd[2:0], 3'b000});
                                slot_req.wr_en = 1'b1;
                            end
                        end else if (slot_rd[3] && found) begin
                            n_held = r_held
                                   | (64'(r_item.key_code) << {open_slot, 3'b000});
                            slot_req.wr_en   = 1'b1;
                            slot_req.wr_data = {1'b0, open_slot};
                        end
                        if (r_count >= QC_W'(kcf_pkg::QUEUE_DEPTH)) begin
                            if (r_ctrl[kcf_pkg::CTRL_OVF_IE]) begin
                                n_flags[kcf_pkg::FLAG_OVF] = 1'b1;
                            end
                        end else begin
                            q_wr_en = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                end
                kcf_pkg::KIND_READ: begin
                    case (r_item.word_address) inside
                        kcf_pkg::A_CTRL: rd = 32'(r_ctrl);
                        kcf_pkg::A_INT: begin
                            rd = 32'(r_flags) | ((r_held != '0) ? 32'd8 : 32'd0)
                               | (32'(r_count) << 4);
                        end
                        [kcf_pkg::A_ROW0:kcf_pkg::A_ROW3]: rd = 32'(r_row[a_row[1:0]]);
                        [kcf_pkg::A_COL0:kcf_pkg::A_COL2]: rd = r_col[a_col[1:0]];
                        kcf_pkg::A_TIMEOUT: rd = 32'(r_timeout);
                        kcf_pkg::A_INIT:    rd = 32'(r_init);
                        kcf_pkg::A_REPEAT:  rd = 32'(r_rep);
                        kcf_pkg::A_POP: begin
                            if (r_count != '0) begin
                                n_latched = q_rd;
                                n_head    = (r_head == QA_W'(kcf_pkg::QUEUE_DEPTH - 1))
                                          ? '0 : r_head + 1'b1;
                                n_count   = r_count - 1'b1;
                            end else begin
                                n_latched = '0;
                            end
                            rd = n_latched[31:0];
                        end
                        kcf_pkg::A_HIGH: rd = r_latched[63:32];
                        [kcf_pkg::A_MASK0:kcf_pkg::A_MASK15]: begin
                            rd = 32'(r_mask[a_mask[3:0]]);
                        end
                        default: rd = '0;
                    endcase
                end
                kcf_pkg::KIND_WRITE: begin
                    case (r_item.word_address) inside
                        kcf_pkg::A_CTRL: begin
                            n_ctrl   = r_item.write_data[18:0];
                            do_raise = 1'b1;
                        end
                        kcf_pkg::A_INT: begin
                            n_flags  = r_flags & ~r_item.write_data[2:0];
                            do_raise = 1'b1;
                        end
                        [kcf_pkg::A_ROW0:kcf_pkg::A_ROW3]: begin
                            n_row[a_row[1:0]] = r_item.write_data[29:0];
                        end
                        [kcf_pkg::A_COL0:kcf_pkg::A_COL2]: begin
                            n_col[a_col[1:0]] = r_item.write_data;
                        end
                        kcf_pkg::A_TIMEOUT: n_timeout = r_item.write_data[19:0];
                        kcf_pkg::A_INIT:    n_init    = r_item.write_data[19:0];
                        kcf_pkg::A_REPEAT:  n_rep     = r_item.write_data[19:0];
                        [kcf_pkg::A_MASK0:kcf_pkg::A_MASK15]: begin
                            n_mask[a_mask[3:0]] = r_item.write_data[7:0];
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase

            if (do_raise) begin
                if (n_ctrl[kcf_pkg::CTRL_CNT_IE]
                    && (32'(n_count) >= 32'(n_ctrl[17:14]))) begin
                    n_flags[kcf_pkg::FLAG_CNT] = 1'b1;
                end
                if (n_ctrl[kcf_pkg::CTRL_PRESS_IE] && is_event) begin
                    n_flags[kcf_pkg::FLAG_KEY] = 1'b1;
                end
            end

            n_out_valid          = 1'b1;
            n_out_item.read_data = rd;
            n_out_item.irq      = (n_flags != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kcf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_ctrl      <= kcf_pkg::CTRL_RESET;
            r_flags     <= '0;
            r_row       <= '{default: '0};
            r_col       <= '{default: '0};
            r_timeout   <= kcf_pkg::TIMEOUT_RESET;
            r_init      <= kcf_pkg::DELAY_RESET;
            r_rep       <= kcf_pkg::DELAY_RESET;
            r_mask      <= '{default: '0};
            r_held      <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_latched   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ctrl      <= n_ctrl;
            r_flags     <= n_flags;
            r_row       <= n_row;
            r_col       <= n_col;
            r_timeout   <= n_timeout;
            r_init      <= n_init;
            r_rep       <= n_rep;
            r_mask      <= n_mask;
            r_held      <= n_held;
            r_head      <= n_head;
            r_count     <= n_count;
            r_latched   <= n_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_out_item <= n_out_item;
    end

endmodule
`default_nettype wire

// ===== rtl/kcf_checker.sv =====
`default_nettype none
module kcf_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire kcf_pkg::t_in_item  i_in_item,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire kcf_pkg::t_out_item o_out_item,
    input wire logic               i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled while item executes");

    a_result_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in execution");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear the channels");

endmodule

bind keypad_controller_with_fifo kcf_checker u_kcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);
`default_nettype wire
